// ===== sv/lfu_pkg.sv =====
// Shared types and constants for the LFU key/value store.
// No dependencies; compiled first.
`default_nettype none

package lfu_pkg;

    localparam int KEY_W       = 32;
    localparam int VALUE_W     = 32;
    localparam int ACT_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int CAP_REG_W   = 5;
    localparam int NUM_PORT_W  = 5;
    localparam int COUNT_W     = 32;

    localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_GET   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_EVICT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_GET_HIT    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EVICT_DONE = 3'd4;

    localparam logic [CAP_REG_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_APPLY,
        S_REPORT
    } seq_state_t;

    typedef struct packed {
        logic clear;
        logic take;
    } scan_ctl_t;

    typedef struct packed {
        logic match_found;
        logic vic_found;
        logic free_found;
    } scan_flags_t;

    typedef struct packed {
        logic wr_en;
        logic clr_en;
        logic set_en;
    } store_ctl_t;

endpackage

`default_nettype wire

// ===== sv/lfu_if.sv =====
// Request and response channel interfaces for the LFU store.
// Depends on lfu_pkg for field widths.
`default_nettype none

interface lfu_req_if;
    import lfu_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ACT_W-1:0]     action;
    logic [KEY_W-1:0]     lookup_key;
    logic [VALUE_W-1:0]   store_value;
    logic [NUM_PORT_W-1:0] evict_count;

    modport source (output valid, action, lookup_key, store_value, evict_count,
                    input ready);
    modport sink   (input valid, action, lookup_key, store_value, evict_count,
                    output ready);
endinterface

interface lfu_rsp_if;
    import lfu_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [VALUE_W-1:0]    read_value;
    logic                  did_evict;
    logic [KEY_W-1:0]      victim_key;
    logic [NUM_PORT_W-1:0] removed_count;
    logic [NUM_PORT_W-1:0] occupancy;

    modport source (output valid, status, read_value, did_evict, victim_key,
                    removed_count, occupancy, input ready);
    modport sink   (input valid, status, read_value, did_evict, victim_key,
                    removed_count, occupancy, output ready);
endinterface

`default_nettype wire

// ===== sv/lfu_store.sv =====
// Entry storage: key, value and count memories with one registered read port
// and one write port, plus per-slot valid flops. Depends on lfu_pkg.
`default_nettype none

module lfu_store #(
    parameter int MAX_ENTRIES = 16,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32,
    localparam int SLOT_W     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire lfu_pkg::store_ctl_t        ctl,
    input  wire logic [SLOT_W-1:0]          rd_addr,
    input  wire logic [SLOT_W-1:0]          wr_addr,
    input  wire logic [SLOT_W-1:0]          clr_addr,
    input  wire logic [SLOT_W-1:0]          set_addr,
    input  wire logic [KEY_BITS-1:0]        wr_key,
    input  wire logic [VALUE_BITS-1:0]      wr_val,
    input  wire logic [lfu_pkg::COUNT_W-1:0] wr_cnt,
    output logic                            rd_vld,
    output logic [KEY_BITS-1:0]             rd_key,
    output logic [VALUE_BITS-1:0]           rd_val,
    output logic [lfu_pkg::COUNT_W-1:0]     rd_cnt
);
    import lfu_pkg::*;

    logic [KEY_BITS-1:0]   key_mem [MAX_ENTRIES];
    logic [VALUE_BITS-1:0] val_mem [MAX_ENTRIES];
    logic [COUNT_W-1:0]    cnt_mem [MAX_ENTRIES];

    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [MAX_ENTRIES-1:0] valid_next;
    logic                   rd_vld_reg;
    logic [KEY_BITS-1:0]    rd_key_reg;
    logic [VALUE_BITS-1:0]  rd_val_reg;
    logic [COUNT_W-1:0]     rd_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
            cnt_mem[wr_addr] <= wr_cnt;
        end
        rd_key_reg <= key_mem[rd_addr];
        rd_val_reg <= val_mem[rd_addr];
        rd_cnt_reg <= cnt_mem[rd_addr];
    end

    // set wins over clear: a put may evict and refill the same slot
    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.clr_en)
        begin
            valid_next[clr_addr] = 1'b0;
        end
        if (ctl.set_en)
        begin
            valid_next[set_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            rd_vld_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_vld = rd_vld_reg;
    assign rd_key = rd_key_reg;
    assign rd_val = rd_val_reg;
    assign rd_cnt = rd_cnt_reg;

endmodule

`default_nettype wire

// ===== sv/lfu_scan.sv =====
// Shared scan unit: takes one entry per cycle and tracks the key match, the
// lowest free slot and the best victim (count, then value, then slot). Uses lfu_pkg.
`default_nettype none

module lfu_scan #(
    parameter int MAX_ENTRIES = 16,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32,
    localparam int SLOT_W     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire lfu_pkg::scan_ctl_t          ctl,
    input  wire logic [SLOT_W-1:0]           slot,
    input  wire logic [KEY_BITS-1:0]         key_in,
    input  wire logic                        e_vld,
    input  wire logic [KEY_BITS-1:0]         e_key,
    input  wire logic [VALUE_BITS-1:0]       e_val,
    input  wire logic [lfu_pkg::COUNT_W-1:0] e_cnt,
    output lfu_pkg::scan_flags_t             flags,
    output logic [SLOT_W-1:0]                match_slot,
    output logic [VALUE_BITS-1:0]            match_val,
    output logic [lfu_pkg::COUNT_W-1:0]      match_cnt,
    output logic [SLOT_W-1:0]                vic_slot,
    output logic [KEY_BITS-1:0]              vic_key,
    output logic [SLOT_W-1:0]                free_slot
);
    import lfu_pkg::*;

    scan_flags_t           flags_reg, flags_next;
    logic [SLOT_W-1:0]     match_slot_reg, match_slot_next;
    logic [VALUE_BITS-1:0] match_val_reg, match_val_next;
    logic [COUNT_W-1:0]    match_cnt_reg, match_cnt_next;
    logic [SLOT_W-1:0]     vic_slot_reg, vic_slot_next;
    logic [KEY_BITS-1:0]   vic_key_reg, vic_key_next;
    logic [VALUE_BITS-1:0] vic_val_reg, vic_val_next;
    logic [COUNT_W-1:0]    vic_cnt_reg, vic_cnt_next;
    logic [SLOT_W-1:0]     free_slot_reg, free_slot_next;
    logic                  better;

    assign better = !flags_reg.vic_found || (e_cnt < vic_cnt_reg) ||
                    ((e_cnt == vic_cnt_reg) && (e_val < vic_val_reg));

    always_comb
    begin
        flags_next      = flags_reg;
        match_slot_next = match_slot_reg;
        match_val_next  = match_val_reg;
        match_cnt_next  = match_cnt_reg;
        vic_slot_next   = vic_slot_reg;
        vic_key_next    = vic_key_reg;
        vic_val_next    = vic_val_reg;
        vic_cnt_next    = vic_cnt_reg;
        free_slot_next  = free_slot_reg;
        if (ctl.clear)
        begin
            flags_next = '0;
        end
        else if (ctl.take)
        begin
            if (e_vld && (e_key == key_in) && !flags_reg.match_found)
            begin
                flags_next.match_found = 1'b1;
                match_slot_next        = slot;
                match_val_next         = e_val;
                match_cnt_next         = e_cnt;
            end
            if (!e_vld && !flags_reg.free_found)
            begin
                flags_next.free_found = 1'b1;
                free_slot_next        = slot;
            end
            if (e_vld && better)
            begin
                flags_next.vic_found = 1'b1;
                vic_slot_next        = slot;
                vic_key_next         = e_key;
                vic_val_next         = e_val;
                vic_cnt_next         = e_cnt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_slot_reg <= match_slot_next;
        match_val_reg  <= match_val_next;
        match_cnt_reg  <= match_cnt_next;
        vic_slot_reg   <= vic_slot_next;
        vic_key_reg    <= vic_key_next;
        vic_val_reg    <= vic_val_next;
        vic_cnt_reg    <= vic_cnt_next;
        free_slot_reg  <= free_slot_next;
    end

    assign flags      = flags_reg;
    assign match_slot = match_slot_reg;
    assign match_val  = match_val_reg;
    assign match_cnt  = match_cnt_reg;
    assign vic_slot   = vic_slot_reg;
    assign vic_key    = vic_key_reg;
    assign free_slot  = free_slot_reg;

endmodule

`default_nettype wire

// ===== sv/lfu_cache_value_tiebreak.sv =====
// Top level of the LFU key/value store with value tie-break.
// Depends on lfu_pkg, lfu_if, lfu_store and lfu_scan.
//
// Requests arrive on req (valid/ready): put, get or evict, with key, value and
// evict count. Each request gives one response word on rsp (valid/ready) with
// status, read value, victim information, removed count and occupancy.
// capacity is to be written through cfg_wr_en/cfg_wr_data only while the block
// is idle; the user must keep to this, as the block does not enforce it.
// Every request scans all MAX_ENTRIES slots through one shared compare unit,
// one slot per cycle from a single memory read port. A put or get then passes
// through the flush, apply and report states and loads its response into the
// output register once that register is free. An evict of k entries (k clipped
// to occupancy) runs one scan per victim, or a single scan when k is zero.
// req.ready is high only between requests.
// The response sits in an output register; a stalled rsp holds it while the
// next request is accepted and scanned, and that request waits to report
// until the register frees. Reset clears all valid bits at once, sets
// capacity to 16 and drops any pending response.
`default_nettype none

module lfu_cache_value_tiebreak #(
    parameter int MAX_ENTRIES = 16,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    lfu_req_if.sink                            req,
    lfu_rsp_if.source                          rsp,
    input  wire logic                          cfg_wr_en,
    input  wire logic [lfu_pkg::CAP_REG_W-1:0] cfg_wr_data
);
    import lfu_pkg::*;

    localparam int SLOT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W  = (OCC_W > CAP_REG_W) ? OCC_W : CAP_REG_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_ENTRIES - 1);

    seq_state_t            state_reg, state_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    logic                  samp_reg, samp_next;
    logic [SLOT_W-1:0]     samp_idx_reg;
    logic [CAP_REG_W-1:0]  capacity_reg, capacity_next;
    logic [OCC_W-1:0]      occ_reg, occ_next;
    logic [OCC_W-1:0]      remain_reg, remain_next;
    logic [OCC_W-1:0]      removed_reg, removed_next;
    logic [ACT_W-1:0]      act_reg, act_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [VALUE_BITS-1:0] res_rd_reg, res_rd_next;
    logic                  res_did_reg, res_did_next;
    logic [KEY_BITS-1:0]   res_vkey_reg, res_vkey_next;
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [VALUE_BITS-1:0] out_rd_reg, out_rd_next;
    logic                  out_did_reg, out_did_next;
    logic [KEY_BITS-1:0]   out_vkey_reg, out_vkey_next;
    logic [OCC_W-1:0]      out_removed_reg, out_removed_next;
    logic [OCC_W-1:0]      out_occ_reg, out_occ_next;

    store_ctl_t            st_ctl;
    logic [SLOT_W-1:0]     wr_addr, clr_addr, set_addr;
    logic [KEY_BITS-1:0]   wr_key;
    logic [VALUE_BITS-1:0] wr_val;
    logic [COUNT_W-1:0]    wr_cnt;
    logic                  e_vld;
    logic [KEY_BITS-1:0]   e_key;
    logic [VALUE_BITS-1:0] e_val;
    logic [COUNT_W-1:0]    e_cnt;

    scan_ctl_t             sc_ctl;
    scan_flags_t           flags;
    logic [SLOT_W-1:0]     match_slot, vic_slot, free_slot, ins_slot;
    logic [VALUE_BITS-1:0] match_val;
    logic [COUNT_W-1:0]    match_cnt, bump_cnt;
    logic [KEY_BITS-1:0]   vic_key;

    logic                  in_acc, out_free, evict_again, put_evict, ins_ok;
    logic [CAP_W-1:0]      cap_ext, cap_eff, occ_ext, want_ext;
    logic [OCC_W-1:0]      want;

    assign in_acc   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    assign cap_ext  = CAP_W'(capacity_reg);
    assign cap_eff  = (cap_ext == '0) ? CAP_W'(1) :
                      (cap_ext > CAP_W'(MAX_ENTRIES)) ? CAP_W'(MAX_ENTRIES) : cap_ext;
    assign occ_ext  = CAP_W'(occ_reg);
    assign want_ext = (CAP_W'(req.evict_count) > occ_ext) ? occ_ext
                                                           : CAP_W'(req.evict_count);
    assign want     = OCC_W'(want_ext);

    assign bump_cnt    = (match_cnt == {COUNT_W{1'b1}}) ? match_cnt : match_cnt + 1'b1;
    assign put_evict   = !flags.match_found && (occ_ext >= cap_eff) && flags.vic_found;
    assign ins_slot    = (put_evict && (!flags.free_found || (vic_slot < free_slot)))
                         ? vic_slot : free_slot;
    assign ins_ok      = put_evict || flags.free_found;
    assign evict_again = (act_reg == ACT_EVICT) && (remain_reg > OCC_W'(1));

    lfu_store #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (st_ctl),
        .rd_addr  (idx_reg),
        .wr_addr  (wr_addr),
        .clr_addr (clr_addr),
        .set_addr (set_addr),
        .wr_key   (wr_key),
        .wr_val   (wr_val),
        .wr_cnt   (wr_cnt),
        .rd_vld   (e_vld),
        .rd_key   (e_key),
        .rd_val   (e_val),
        .rd_cnt   (e_cnt)
    );

    lfu_scan #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (sc_ctl),
        .slot       (samp_idx_reg),
        .key_in     (key_reg),
        .e_vld      (e_vld),
        .e_key      (e_key),
        .e_val      (e_val),
        .e_cnt      (e_cnt),
        .flags      (flags),
        .match_slot (match_slot),
        .match_val  (match_val),
        .match_cnt  (match_cnt),
        .vic_slot   (vic_slot),
        .vic_key    (vic_key),
        .free_slot  (free_slot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (idx_reg == LAST_SLOT)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                state_next = evict_again ? S_SCAN : S_REPORT;
            end
            S_REPORT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        idx_next         = idx_reg;
        samp_next        = (state_reg == S_SCAN);
        capacity_next    = cfg_wr_en ? cfg_wr_data : capacity_reg;
        remain_next      = remain_reg;
        removed_next     = removed_reg;
        act_next         = act_reg;
        key_next         = key_reg;
        val_next         = val_reg;
        res_status_next  = res_status_reg;
        res_rd_next      = res_rd_reg;
        res_did_next     = res_did_reg;
        res_vkey_next    = res_vkey_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_rd_next      = out_rd_reg;
        out_did_next     = out_did_reg;
        out_vkey_next    = out_vkey_reg;
        out_removed_next = out_removed_reg;
        out_occ_next     = out_occ_reg;
        st_ctl           = '0;
        wr_addr          = match_slot;
        wr_key           = key_reg;
        wr_val           = val_reg;
        wr_cnt           = bump_cnt;
        clr_addr         = vic_slot;
        set_addr         = ins_slot;
        sc_ctl.clear     = 1'b0;
        sc_ctl.take      = samp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    idx_next        = '0;
                    act_next        = req.action;
                    key_next        = KEY_BITS'(req.lookup_key);
                    val_next        = VALUE_BITS'(req.store_value);
                    remain_next     = want;
                    removed_next    = '0;
                    res_status_next = ST_NOT_FOUND;
                    res_rd_next     = '0;
                    res_did_next    = 1'b0;
                    res_vkey_next   = '0;
                    sc_ctl.clear    = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (idx_reg != LAST_SLOT)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_FLUSH:
            begin
                idx_next = idx_reg;
            end
            S_APPLY:
            begin
                case (act_reg)
                    ACT_PUT:
                    begin
                        if (flags.match_found)
                        begin
                            st_ctl.wr_en    = 1'b1;
                            res_status_next = ST_UPDATED;
                        end
                        else
                        begin
                            if (put_evict)
                            begin
                                st_ctl.clr_en = 1'b1;
                                res_did_next  = 1'b1;
                                res_vkey_next = vic_key;
                                removed_next  = OCC_W'(1);
                            end
                            if (ins_ok)
                            begin
                                st_ctl.wr_en  = 1'b1;
                                st_ctl.set_en = 1'b1;
                                wr_addr       = ins_slot;
                                wr_cnt        = COUNT_W'(1);
                            end
                            res_status_next = ST_INSERTED;
                        end
                    end
                    ACT_GET:
                    begin
                        if (flags.match_found)
                        begin
                            st_ctl.wr_en    = 1'b1;
                            wr_val          = match_val;
                            res_rd_next     = match_val;
                            res_status_next = ST_GET_HIT;
                        end
                    end
                    ACT_EVICT:
                    begin
                        res_status_next = ST_EVICT_DONE;
                        if (remain_reg != '0)
                        begin
                            st_ctl.clr_en = 1'b1;
                            removed_next  = removed_reg + 1'b1;
                            remain_next   = remain_reg - 1'b1;
                        end
                        if (evict_again)
                        begin
                            idx_next     = '0;
                            sc_ctl.clear = 1'b1;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_NOT_FOUND;
                    end
                endcase
            end
            S_REPORT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_rd_next      = res_rd_reg;
                    out_did_next     = res_did_reg;
                    out_vkey_next    = res_vkey_reg;
                    out_removed_next = removed_reg;
                    out_occ_next     = occ_reg;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase

        occ_next = occ_reg - OCC_W'(st_ctl.clr_en) + OCC_W'(st_ctl.set_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            samp_reg      <= 1'b0;
            capacity_reg  <= CAP_RESET;
            occ_reg       <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            samp_reg      <= samp_next;
            capacity_reg  <= capacity_next;
            occ_reg       <= occ_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_idx_reg    <= idx_reg;
        removed_reg     <= removed_next;
        act_reg         <= act_next;
        key_reg         <= key_next;
        val_reg         <= val_next;
        res_status_reg  <= res_status_next;
        res_rd_reg      <= res_rd_next;
        res_did_reg     <= res_did_next;
        res_vkey_reg    <= res_vkey_next;
        out_status_reg  <= out_status_next;
        out_rd_reg      <= out_rd_next;
        out_did_reg     <= out_did_next;
        out_vkey_reg    <= out_vkey_next;
        out_removed_reg <= out_removed_next;
        out_occ_reg     <= out_occ_next;
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.read_value    = VALUE_W'(out_rd_reg);
    assign rsp.did_evict     = out_did_reg;
    assign rsp.victim_key    = KEY_W'(out_vkey_reg);
    assign rsp.removed_count = NUM_PORT_W'(out_removed_reg);
    assign rsp.occupancy     = NUM_PORT_W'(out_occ_reg);

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(MAX_ENTRIES))
        else $error("occupancy above slot count");

    a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH) |-> (samp_reg && (samp_idx_reg == LAST_SLOT)))
        else $error("scan flush without last slot in flight");

    a_evict_victim: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_APPLY) && (act_reg == ACT_EVICT) && (remain_reg != '0))
        |-> flags.vic_found)
        else $error("evict round found no victim");

    a_put_victim: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_APPLY) && (act_reg == ACT_PUT) && !flags.match_found &&
         (occ_ext >= cap_eff)) |-> flags.vic_found)
        else $error("full store put found no victim");

    a_report: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_REPORT) && out_free) |=> (rsp.valid && (state_reg == S_IDLE)))
        else $error("response not loaded on report");

endmodule

`default_nettype wire

// ===== bench/lfu_cache_value_tiebreak_checker.sv =====
// Reply checker for the LFU key/value store: mirrors the store contents,
// predicts each reply from accepted request words and compares field by field.
// Depends on lfu_pkg and the lfu_req_if / lfu_rsp_if channel interfaces.
`timescale 1ns / 1ps

module lfu_cache_value_tiebreak_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    lfu_req_if                            req,
    lfu_rsp_if                            rsp,
    input  logic                          cfg_wr_en,
    input  logic [lfu_pkg::CAP_REG_W-1:0] cfg_wr_data,
    output int                            mismatches,
    output int                            replies_due
);
    import lfu_pkg::*;

    localparam int SLOTS = 16;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [VALUE_W-1:0]    read_value;
        logic                  did_evict;
        logic [KEY_W-1:0]      victim_key;
        logic [NUM_PORT_W-1:0] removed_count;
        logic [NUM_PORT_W-1:0] occupancy;
    } reply_t;

    logic                 slot_valid [SLOTS];
    logic [KEY_W-1:0]     slot_key   [SLOTS];
    logic [VALUE_W-1:0]   slot_value [SLOTS];
    logic [COUNT_W-1:0]   slot_uses  [SLOTS];
    logic [CAP_REG_W-1:0] capacity;
    reply_t               pending_replies [$];
    reply_t               got;
    reply_t               want;
    int                   bad_words;

    function automatic int live_entries();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i])
                n++;
        return n;
    endfunction

    function automatic int find_key(input logic [KEY_W-1:0] key);
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && slot_key[i] == key)
                return i;
        return -1;
    endfunction

    // lowest use count, then lowest value, then lowest slot
    function automatic int pick_victim();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!slot_valid[i])
                continue;
            if (best < 0 || slot_uses[i] < slot_uses[best] ||
                (slot_uses[i] == slot_uses[best] && slot_value[i] < slot_value[best]))
                best = i;
        end
        return best;
    endfunction

    task automatic bump_uses(input int s);
        if (slot_uses[s] != '1)
            slot_uses[s] = slot_uses[s] + 1'b1;
    endtask

    task automatic run_store_op(input logic [ACT_W-1:0] act,
                                input logic [KEY_W-1:0] key,
                                input logic [VALUE_W-1:0] value,
                                input logic [NUM_PORT_W-1:0] count,
                                output reply_t r);
        int slot;
        int v;
        int lim;
        int occ;
        r = '0;
        r.status = ST_NOT_FOUND;
        if (capacity == 0)
            lim = 1;
        else if (capacity > SLOTS)
            lim = SLOTS;
        else
            lim = capacity;
        case (act)
            ACT_PUT:
            begin
                slot = find_key(key);
                if (slot >= 0)
                begin
                    slot_value[slot] = value;
                    bump_uses(slot);
                    r.status = ST_UPDATED;
                end
                else
                begin
                    if (live_entries() >= lim)
                    begin
                        v = pick_victim();
                        if (v >= 0)
                        begin
                            slot_valid[v] = 1'b0;
                            r.did_evict = 1'b1;
                            r.victim_key = slot_key[v];
                            r.removed_count = NUM_PORT_W'(1);
                        end
                    end
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!slot_valid[i])
                        begin
                            slot_valid[i] = 1'b1;
                            slot_key[i] = key;
                            slot_value[i] = value;
                            slot_uses[i] = COUNT_W'(1);
                            break;
                        end
                    end
                    r.status = ST_INSERTED;
                end
            end
            ACT_GET:
            begin
                slot = find_key(key);
                if (slot >= 0)
                begin
                    bump_uses(slot);
                    r.read_value = slot_value[slot];
                    r.status = ST_GET_HIT;
                end
            end
            ACT_EVICT:
            begin
                occ = live_entries();
                if (count < occ)
                    occ = count;
                for (int k = 0; k < occ; k++)
                begin
                    v = pick_victim();
                    slot_valid[v] = 1'b0;
                end
                r.removed_count = NUM_PORT_W'(occ);
                r.status = ST_EVICT_DONE;
            end
            default:
            begin
            end
        endcase
        r.occupancy = NUM_PORT_W'(live_entries());
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                slot_valid[i] = 1'b0;
            capacity = CAP_RESET;
            pending_replies.delete();
            bad_words = 0;
            replies_due <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                capacity = cfg_wr_data;
            if (rsp.valid && rsp.ready)
            begin
                got.status = rsp.status;
                got.read_value = rsp.read_value;
                got.did_evict = rsp.did_evict;
                got.victim_key = rsp.victim_key;
                got.removed_count = rsp.removed_count;
                got.occupancy = rsp.occupancy;
                if (pending_replies.size() == 0)
                begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display("unexpected reply word: status=%0d occ=%0d",
                                 got.status, got.occupancy);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (got !== want)
                    begin
                        bad_words++;
                        if (bad_words <= 10)
                            $display({"reply mismatch: exp status=%0d value=%h evict=%0d ",
                                      "victim=%h removed=%0d occ=%0d / got status=%0d ",
                                      "value=%h evict=%0d victim=%h removed=%0d occ=%0d"},
                                     want.status, want.read_value, want.did_evict,
                                     want.victim_key, want.removed_count, want.occupancy,
                                     got.status, got.read_value, got.did_evict,
                                     got.victim_key, got.removed_count, got.occupancy);
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                run_store_op(req.action, req.lookup_key, req.store_value,
                             req.evict_count, want);
                pending_replies = {pending_replies, want};
            end
            replies_due <= pending_replies.size();
            mismatches <= bad_words;
        end
    end

endmodule

// ===== bench/lfu_cache_value_tiebreak_tb.sv =====
// Top of the LFU key/value store bench: clock, reset, request and reply traffic,
// capacity changes and the final verdict. Depends on lfu_pkg, lfu_if, the store
// RTL and lfu_cache_value_tiebreak_checker.
`timescale 1ns / 1ps

module lfu_cache_value_tiebreak_tb;
    import lfu_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 40;
    localparam int PHASE_WORDS    = 110;
    localparam int PHASES         = 8;
    localparam int POOL_MAX       = 24;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CAP_REG_W-1:0] cfg_wr_data;
    int                   mismatches;
    int                   replies_due;
    int                   idle_cycles = 0;
    int                   burst_left;
    bit                   hold_off_request;
    int                   pool_size;
    logic [KEY_W-1:0]     key_pool [POOL_MAX];
    logic [CAP_REG_W-1:0] cap_plan [PHASES];

    lfu_req_if req_ch();
    lfu_rsp_if rsp_ch();

    lfu_cache_value_tiebreak DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    lfu_cache_value_tiebreak_checker reply_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mismatches  (mismatches),
        .replies_due (replies_due)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : receiver
        int mode;
        int left;
        int beat;
        rsp_ch.ready <= 1'b0;
        mode = 0;
        left = 0;
        beat = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                // hold off long enough for the store to back up its input
                rsp_ch.ready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++)
                    @(posedge clk);
                hold_off_request = 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 150);
                end
                left--;
                beat++;
                case (mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready <= ((beat % 7) < 4);
                endcase
            end
        end
    end

    task automatic send_word(input logic [ACT_W-1:0] act,
                             input logic [KEY_W-1:0] key,
                             input logic [VALUE_W-1:0] value,
                             input logic [NUM_PORT_W-1:0] count);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 24);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.action <= act;
        req_ch.lookup_key <= key;
        req_ch.store_value <= value;
        req_ch.evict_count <= count;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (replies_due != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_REG_W-1:0] cap);
        drain();
        cfg_wr_data <= cap;
        cfg_wr_en <= 1'b1;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic fill_pool();
        pool_size = $urandom_range(3, POOL_MAX);
        for (int i = 0; i < POOL_MAX; i++)
            key_pool[i] = $urandom;
        if ($urandom_range(0, 3) == 0)
            key_pool[0] = '0;
        if ($urandom_range(0, 3) == 0)
            key_pool[pool_size-1] = '1;
    endtask

    task automatic random_word();
        int pick;
        logic [ACT_W-1:0]      act;
        logic [KEY_W-1:0]      key;
        logic [VALUE_W-1:0]    value;
        logic [NUM_PORT_W-1:0] count;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            act = ACT_PUT;
        else if (pick < 80)
            act = ACT_GET;
        else if (pick < 92)
            act = ACT_EVICT;
        else
            act = ACT_UNUSED;
        if ($urandom_range(0, 99) < 85)
            key = key_pool[$urandom_range(0, pool_size - 1)];
        else
            key = $urandom;
        case ($urandom_range(0, 9))
            0: value = '0;
            1: value = '1;
            2: value = 32'd3;
            default: value = $urandom;
        endcase
        pick = $urandom_range(0, 19);
        if (pick < 16)
            count = NUM_PORT_W'($urandom_range(0, 3));
        else if (pick < 19)
            count = NUM_PORT_W'($urandom_range(4, 16));
        else
            count = NUM_PORT_W'($urandom_range(17, 31));
        send_word(act, key, value, count);
    endtask

    initial
    begin : stimulus
        req_ch.valid <= 1'b0;
        req_ch.action <= ACT_PUT;
        req_ch.lookup_key <= '0;
        req_ch.store_value <= '0;
        req_ch.evict_count <= '0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        rst_n <= 1'b0;
        burst_left = 0;
        hold_off_request = 1'b0;
        cap_plan = '{5'd1, 5'd31, 5'd0, 5'd16, 5'd3, 5'd0, 5'd8, 5'd2};
        cap_plan[5] = CAP_REG_W'($urandom_range(0, 31));
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(ACT_GET, '0, '0, '0);
        send_word(ACT_EVICT, '0, '0, 5'd5);
        send_word(ACT_PUT, '0, '1, '0);
        send_word(ACT_PUT, '1, '0, '0);
        send_word(ACT_PUT, '0, 32'd7, '0);
        send_word(ACT_GET, '1, '0, '0);
        send_word(ACT_GET, 32'h1234_5678, '0, '0);
        send_word(ACT_UNUSED, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 5'd16);
        send_word(ACT_PUT, 32'd1, 32'd3, '0);
        send_word(ACT_PUT, 32'd2, 32'd3, '0);
        send_word(ACT_EVICT, '0, '0, 5'd0);
        send_word(ACT_EVICT, '0, '0, 5'd1);
        send_word(ACT_EVICT, '0, '0, 5'd31);
        for (int i = 0; i < 5; i++)
            send_word(ACT_PUT, 32'd10 + i, 32'd9 - i, '0);
        // shrink below occupancy: a put miss drops only one entry
        set_capacity(5'd1);
        send_word(ACT_PUT, 32'd20, 32'd1, '0);
        send_word(ACT_GET, 32'd20, '0, '0);
        send_word(ACT_EVICT, '0, '0, 5'd16);
        send_word(ACT_PUT, 32'd30, 32'd1, '0);
        send_word(ACT_PUT, 32'd31, 32'd2, '0);

        for (int p = 0; p < PHASES; p++)
        begin
            set_capacity(cap_plan[p]);
            fill_pool();
            if (p == 2 || p == 5)
                hold_off_request = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++)
                random_word();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && replies_due == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
